// File: hw/rtl/shdf_pkg.sv
// Package for the sync header packet deframer.
// Event codes, header framing constants and the result record.
// No dependencies.
package shdf_pkg;

  localparam int HeaderBytes = 9;
  localparam int WinDepth    = HeaderBytes - 1;
  localparam int FillW       = $clog2(WinDepth + 1);
  localparam int WinIdxW     = $clog2(WinDepth);

  localparam logic [7:0]  SyncHi    = 8'hFF;
  localparam logic [7:0]  SyncLo    = 8'h5A;
  localparam logic [15:0] HeaderLen = 16'(HeaderBytes);

  typedef enum logic [2:0] {
    EvHdrPayload = 3'd0,
    EvHdrOnly    = 3'd1,
    EvPayload    = 3'd2,
    EvEndGood    = 3'd3,
    EvEndBad     = 3'd4
  } event_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_beat_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  payload_byte;
    logic [15:0] packet_length;
    logic [7:0]  control_bits;
    logic [7:0]  seq_number;
    logic [7:0]  ack_number;
    logic [7:0]  session;
  } result_t;

endpackage

// File: hw/rtl/shdf_if.sv
// Stream interfaces of the deframer: received bytes in, events out.
// Depends on shdf_pkg.
interface shdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shdf_ev_if;
  logic             valid;
  logic             ready;
  shdf_pkg::event_e event_res;
  logic [7:0]       payload_byte;
  logic [15:0]      packet_length;
  logic [7:0]       control_bits;
  logic [7:0]       seq_number;
  logic [7:0]       ack_number;
  logic [7:0]       session;

  modport source (output valid, output event_res, output payload_byte,
                  output packet_length, output control_bits, output seq_number,
                  output ack_number, output session, input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input packet_length, input control_bits, input seq_number,
                  input ack_number, input session, output ready);
endinterface

// File: hw/rtl/shdf_in_reg.sv
// Input register of the deframer: holds one received byte until the core
// consumes it. Depends on shdf_pkg and shdf_rx_if.
module shdf_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  shdf_rx_if.sink            rx_i,
  input  logic               advance_i,
  output shdf_pkg::rx_beat_t beat_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;

  assign rx_i.ready = !vld_q || advance_i;

  always_comb begin
    vld_d = vld_q;
    if (rx_i.valid && rx_i.ready) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      data_q <= rx_i.rx_byte;
    end
  end

  assign beat_o.valid = vld_q;
  assign beat_o.data  = data_q;

endmodule

// File: hw/rtl/shdf_core.sv
// Deframer core: hunt window, header check, payload count and checksum.
// Produces at most one result per consumed byte. Depends on shdf_pkg.
module shdf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          byte_i,
  output logic                res_vld_o,
  output shdf_pkg::result_t   res_o
);

  logic [7:0]                 win_q [shdf_pkg::WinDepth];
  logic [7:0]                 win_d [shdf_pkg::WinDepth];
  logic [shdf_pkg::FillW-1:0] fill_q, fill_d;
  logic                       in_pay_q, in_pay_d;
  logic [15:0]                left_q, left_d;
  logic [7:0]                 psum_q, psum_d;

  logic [7:0]  win_sum;
  logic [7:0]  total;
  logic [15:0] hdr_len;
  logic        hdr_ok;

  always_comb begin
    win_sum = byte_i;
    for (int i = 0; i < shdf_pkg::WinDepth; i++) begin
      win_sum = win_sum + win_q[i];
    end
  end

  assign total   = psum_q + byte_i;
  assign hdr_len = {win_q[2], win_q[3]};
  assign hdr_ok  = (win_q[0] == shdf_pkg::SyncHi) && (win_q[1] == shdf_pkg::SyncLo) &&
                   (win_sum == 8'd0) && (hdr_len >= shdf_pkg::HeaderLen);

  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    in_pay_d  = in_pay_q;
    left_d    = left_q;
    psum_d    = psum_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (in_pay_q) begin
      res_vld_o = 1'b1;
      if (left_q > 16'd1) begin
        left_d             = left_q - 16'd1;
        psum_d             = total;
        res_o.event_res    = shdf_pkg::EvPayload;
        res_o.payload_byte = byte_i;
      end else begin
        in_pay_d        = 1'b0;
        left_d          = '0;
        psum_d          = '0;
        fill_d          = '0;
        res_o.event_res = (total == 8'd0) ? shdf_pkg::EvEndGood : shdf_pkg::EvEndBad;
      end
    end else if (fill_q < shdf_pkg::FillW'(shdf_pkg::WinDepth)) begin
      win_d[fill_q[shdf_pkg::WinIdxW-1:0]] = byte_i;
      fill_d = fill_q + 1'b1;
    end else if (hdr_ok) begin
      res_vld_o           = 1'b1;
      fill_d              = '0;
      res_o.packet_length = hdr_len;
      res_o.control_bits  = win_q[4];
      res_o.seq_number    = win_q[5];
      res_o.ack_number    = win_q[6];
      res_o.session       = win_q[7];
      if (hdr_len == shdf_pkg::HeaderLen) begin
        res_o.event_res = shdf_pkg::EvHdrOnly;
      end else begin
        res_o.event_res = shdf_pkg::EvHdrPayload;
        in_pay_d        = 1'b1;
        left_d          = hdr_len - shdf_pkg::HeaderLen;
        psum_d          = '0;
      end
    end else begin
      for (int i = 0; i < shdf_pkg::WinDepth - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[shdf_pkg::WinDepth-1] = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      in_pay_q <= 1'b0;
      left_q   <= '0;
      psum_q   <= '0;
    end else if (advance_i) begin
      fill_q   <= fill_d;
      in_pay_q <= in_pay_d;
      left_q   <= left_d;
      psum_q   <= psum_d;
    end
  end

  // window entries at or above the fill count are never read
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q <= win_d;
    end
  end

endmodule

// File: hw/rtl/shdf_out_reg.sv
// Output register of the deframer: holds one event until the sink takes it.
// Depends on shdf_pkg and shdf_ev_if.
module shdf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  shdf_pkg::result_t res_i,
  output logic              free_o,
  shdf_ev_if.source         ev_o
);

  logic              vld_q, vld_d;
  shdf_pkg::result_t res_q;

  assign free_o = !vld_q || ev_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ev_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign ev_o.valid         = vld_q;
  assign ev_o.event_res     = res_q.event_res;
  assign ev_o.payload_byte  = res_q.payload_byte;
  assign ev_o.packet_length = res_q.packet_length;
  assign ev_o.control_bits  = res_q.control_bits;
  assign ev_o.seq_number    = res_q.seq_number;
  assign ev_o.ack_number    = res_q.ack_number;
  assign ev_o.session       = res_q.session;

endmodule

// File: hw/rtl/sync_header_packet_deframer.sv
// Sync header packet deframer: hunts a 9-byte header (0xFF 0x5A, big-endian
// length, control, sequence, ack, session, zero byte sum) in a byte stream,
// then forwards payload bytes and a checksum verdict. Each byte passes the
// input register, the core logic and the output register; throughput is one
// byte per cycle while the sink is ready. Payload is forwarded before its
// checksum is known; discard it on an end-bad event. Depends on shdf_pkg,
// shdf_if, shdf_in_reg, shdf_core and shdf_out_reg.
module sync_header_packet_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  shdf_rx_if.sink   rx_i,
  shdf_ev_if.source ev_o
);

  shdf_pkg::rx_beat_t beat;
  shdf_pkg::result_t  res;
  logic               res_vld;
  logic               out_free;
  logic               advance;

  assign advance = beat.valid && out_free;

  shdf_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .rx_i,
    .advance_i (advance),
    .beat_o    (beat)
  );

  shdf_core u_core (
    .clk_i,
    .rst_ni,
    .advance_i (advance),
    .byte_i    (beat.data),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  shdf_out_reg u_out_reg (
    .clk_i,
    .rst_ni,
    .load_i (advance && res_vld),
    .res_i  (res),
    .free_o (out_free),
    .ev_o
  );

endmodule

// File: hw/rtl/shdf_checker.sv
// Port-level checks of the deframer event stream, bound to the top level.
// Depends on shdf_pkg and sync_header_packet_deframer.
module shdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ev_valid_i,
  input logic        ev_ready_i,
  input logic [2:0]  event_res_i,
  input logic [7:0]  payload_byte_i,
  input logic [15:0] packet_length_i
);

  logic is_hdr;
  assign is_hdr = (event_res_i == shdf_pkg::EvHdrPayload) ||
                  (event_res_i == shdf_pkg::EvHdrOnly);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(event_res_i))
    else $error("event changed while stalled");

  a_hdr_only_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && event_res_i == shdf_pkg::EvHdrOnly |->
      packet_length_i == shdf_pkg::HeaderLen)
    else $error("header-only event with wrong length");

  a_hdr_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && event_res_i == shdf_pkg::EvHdrPayload |->
      packet_length_i > shdf_pkg::HeaderLen)
    else $error("payload header with short length");

  a_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !is_hdr |-> packet_length_i == 16'd0)
    else $error("length on non-header event");

  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && event_res_i != shdf_pkg::EvPayload |-> payload_byte_i == 8'd0)
    else $error("data byte on non-payload event");

endmodule

bind sync_header_packet_deframer shdf_checker u_shdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .ev_valid_i      (ev_o.valid),
  .ev_ready_i      (ev_o.ready),
  .event_res_i     (ev_o.event_res),
  .payload_byte_i  (ev_o.payload_byte),
  .packet_length_i (ev_o.packet_length)
);

// File: tb/sync_header_packet_deframer_test.sv
// Testbench for sync_header_packet_deframer: directed frames, then random byte streams.
// Events are checked against fixed directed events or a cycle-free frame predictor.
// Depends on shdf_pkg, shdf_if and the deframer RTL.
module sync_header_packet_deframer_test;

  typedef struct {
    logic [7:0]        b;
    bit                fixed;
    shdf_pkg::result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  shdf_rx_if rx ();
  shdf_ev_if ev ();

  sync_header_packet_deframer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx),
    .ev_o  (ev)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [7:0]                 win [shdf_pkg::WinDepth];
  logic [shdf_pkg::FillW-1:0] fill;
  logic                       in_pl;
  logic [15:0]                left;
  logic [7:0]                 psum;

  shdf_pkg::result_t events_due [$];
  dir_row_t          directed_bytes [$];
  logic [7:0]        rx_stream [$];
  shdf_pkg::result_t due;
  int                mismatches = 0;
  bit                src_idle = 1'b1;
  bit                sink_stall_on = 1'b1;

  function automatic void clear_hunt();
    for (int i = 0; i < shdf_pkg::WinDepth; i++) win[i] = 8'h00;
    fill = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output shdf_pkg::result_t r);
    logic [7:0]  sum;
    logic [15:0] len;
    r = '0;
    if (in_pl) begin
      if (left > 16'd1) begin
        left = left - 16'd1;
        psum = psum + b;
        r.event_res = shdf_pkg::EvPayload;
        r.payload_byte = b;
        return 1'b1;
      end
      r.event_res = (8'(psum + b) == 8'h00) ? shdf_pkg::EvEndGood : shdf_pkg::EvEndBad;
      in_pl = 1'b0;
      left = '0;
      psum = '0;
      clear_hunt();
      return 1'b1;
    end
    if (fill < shdf_pkg::WinDepth) begin
      win[fill[shdf_pkg::WinIdxW-1:0]] = b;
      fill = fill + 1'b1;
      return 1'b0;
    end
    sum = b;
    for (int i = 0; i < shdf_pkg::WinDepth; i++) sum = sum + win[i];
    len = {win[2], win[3]};
    if (win[0] == shdf_pkg::SyncHi && win[1] == shdf_pkg::SyncLo && sum == 8'h00 &&
        len >= shdf_pkg::HeaderLen) begin
      r.packet_length = len;
      r.control_bits = win[4];
      r.seq_number = win[5];
      r.ack_number = win[6];
      r.session = win[7];
      clear_hunt();
      if (len == shdf_pkg::HeaderLen) begin
        r.event_res = shdf_pkg::EvHdrOnly;
        return 1'b1;
      end
      in_pl = 1'b1;
      left = len - shdf_pkg::HeaderLen;
      psum = '0;
      r.event_res = shdf_pkg::EvHdrPayload;
      return 1'b1;
    end
    for (int i = 0; i < shdf_pkg::WinDepth - 1; i++) win[i] = win[i + 1];
    win[shdf_pkg::WinDepth - 1] = b;
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_row(input logic [7:0] b);
    dir_row_t row;
    row.b = b;
    row.fixed = 1'b0;
    row.want = '0;
    directed_bytes = {directed_bytes, row};
  endtask

  task automatic add_fixed(input logic [7:0] b, input shdf_pkg::result_t want);
    dir_row_t row;
    row.b = b;
    row.fixed = 1'b1;
    row.want = want;
    directed_bytes = {directed_bytes, row};
  endtask

  // bad_at < 0: intact header; otherwise that byte is corrupted
  task automatic queue_header(input logic [15:0] len, input int bad_at);
    logic [7:0] hdr [shdf_pkg::HeaderBytes];
    logic [7:0] sum;
    hdr[0] = shdf_pkg::SyncHi;
    hdr[1] = shdf_pkg::SyncLo;
    hdr[2] = len[15:8];
    hdr[3] = len[7:0];
    for (int i = 4; i < shdf_pkg::WinDepth; i++) hdr[i] = 8'($urandom_range(0, 255));
    sum = 8'h00;
    for (int i = 0; i < shdf_pkg::WinDepth; i++) sum = sum + hdr[i];
    hdr[shdf_pkg::WinDepth] = 8'h00 - sum;
    if (bad_at >= 0) hdr[bad_at] = hdr[bad_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < shdf_pkg::HeaderBytes; i++) rx_stream = {rx_stream, hdr[i]};
  endtask

  task automatic queue_packet(input logic [15:0] len, input bit good);
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] chk;
    queue_header(len, -1);
    if (len > shdf_pkg::HeaderLen) begin
      sum = 8'h00;
      repeat (int'(len) - shdf_pkg::HeaderBytes - 1) begin
        d = 8'($urandom_range(0, 255));
        sum = sum + d;
        rx_stream = {rx_stream, d};
      end
      chk = 8'h00 - sum;
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      rx_stream = {rx_stream, chk};
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
  endtask

  task automatic feed(input logic [7:0] b, input bit fixed, input shdf_pkg::result_t want);
    shdf_pkg::result_t r;
    bit                has;
    send_byte(b);
    has = deframe_byte(b, r);
    if (fixed) events_due = {events_due, want};
    else if (has) events_due = {events_due, r};
  endtask

  // Event sink with random stall bursts
  initial begin
    ev.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        ev.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      ev.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && ev.valid && ev.ready) begin
      if (events_due.size() == 0) begin
        $error("event_res: no event due, got %0d", ev.event_res);
        mismatches++;
      end else begin
        due = events_due.pop_front();
        check_field("event_res", 16'(due.event_res), 16'(ev.event_res));
        check_field("payload_byte", 16'(due.payload_byte), 16'(ev.payload_byte));
        check_field("packet_length", due.packet_length, ev.packet_length);
        check_field("control_bits", 16'(due.control_bits), 16'(ev.control_bits));
        check_field("seq_number", 16'(due.seq_number), 16'(ev.seq_number));
        check_field("ack_number", 16'(due.ack_number), 16'(ev.ack_number));
        check_field("session", 16'(due.session), 16'(ev.session));
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [7:0]  b;
    logic [15:0] len;
    int unsigned pick;
    int unsigned n;
    rst_n <= 1'b0;
    rx.valid <= 1'b0;
    rx.rx_byte <= 8'h00;
    in_pl = 1'b0;
    left = '0;
    psum = '0;
    clear_hunt();

    // Leading stray byte rejects the first window, then a header-only packet
    add_row(8'h5A);
    add_row(8'hFF); add_row(8'h5A); add_row(8'h00); add_row(8'h09);
    add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_fixed(8'h9E, shdf_pkg::result_t'{shdf_pkg::EvHdrOnly, 8'h00, 16'd9,
                                         8'h00, 8'h00, 8'h00, 8'h00});
    // Length 11, all-ones header fields, one payload byte, bad checksum
    add_row(8'hFF); add_row(8'h5A); add_row(8'h00); add_row(8'h0B);
    add_row(8'hFF); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
    add_fixed(8'hA0, shdf_pkg::result_t'{shdf_pkg::EvHdrPayload, 8'h00, 16'd11,
                                         8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add_fixed(8'hFF, shdf_pkg::result_t'{shdf_pkg::EvPayload, 8'hFF, 16'd0,
                                         8'h00, 8'h00, 8'h00, 8'h00});
    add_fixed(8'h00, shdf_pkg::result_t'{shdf_pkg::EvEndBad, 8'h00, 16'd0,
                                         8'h00, 8'h00, 8'h00, 8'h00});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (directed_bytes.size() != 0) begin
      row = directed_bytes.pop_front();
      feed(row.b, row.fixed, row.want);
    end

    // Drain fully before the random stream
    rx.valid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);

    queue_packet(16'd300, 1'b1);
    while (rx_stream.size() < 1150) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) rx_stream = {rx_stream, 8'($urandom_range(0, 255))};
      end else if (pick == 1) begin
        if ($urandom_range(0, 1) == 1) queue_header(16'($urandom_range(0, 8)), -1);
        else queue_header(16'(9 + $urandom_range(0, 12)), int'($urandom_range(0, 8)));
      end else begin
        if ($urandom_range(0, 3) == 0) len = shdf_pkg::HeaderLen;
        else if ($urandom_range(0, 9) == 0) len = 16'(9 + $urandom_range(1, 60));
        else len = 16'(9 + $urandom_range(1, 12));
        queue_packet(len, $urandom_range(0, 3) != 0);
      end
    end

    n = 0;
    while (rx_stream.size() != 0) begin
      if (rx_stream.size() <= 150) begin
        src_idle = 1'b0;
        sink_stall_on = 1'b0;
      end else if (n % 64 == 0) begin
        src_idle = $urandom_range(0, 3) != 0;
        sink_stall_on = $urandom_range(0, 3) != 0;
      end
      b = rx_stream.pop_front();
      feed(b, 1'b0, '0);
      n++;
    end
    rx.valid <= 1'b0;

    while (events_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #1600000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
